// ----- rtl/dwd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwd_pkg
// Shared widths, codes, types and helpers for the differential wheel drive.
// ----------------------------------------------------------------------------
package dwd_pkg;

    localparam int FULL_SCALE = 32768;
    localparam int THR_W      = 17;              // throttle field
    localparam int RAD_W      = 16;              // radius field
    localparam int DIR_W      = 2;               // turn direction field
    localparam int CFG_W      = 16;              // both registers
    localparam int DUTY_W     = 8;
    localparam int TMAG_W     = 16;              // |throttle| after clamp, up to 32768
    localparam int DEN_W      = RAD_W + 1;       // 2R
    localparam int NUM_W      = DEN_W + 1;       // |2R -/+ W|
    localparam int MAG_W      = TMAG_W + NUM_W;  // |t * num|
    localparam int QUO_W      = 16;              // quotient bits kept below the overflow flag
    localparam int DIV_STAGES = QUO_W + 1;       // overflow check plus one stage per bit
    localparam int PIPE_DEPTH = 2 + DIV_STAGES;  // prep, multiply, divider

    localparam logic [DIR_W-1:0] DIR_STRAIGHT = 2'd0;
    localparam logic [DIR_W-1:0] DIR_LEFT     = 2'd1;
    localparam logic [DIR_W-1:0] DIR_RIGHT    = 2'd2;

    // Register select, byte address bit 2
    localparam logic REG_TRACK = 1'b0;
    localparam logic REG_MIN   = 1'b1;

    localparam logic [CFG_W-1:0] TRACK_RESET = 16'd200;
    localparam logic [CFG_W-1:0] MIN_RESET   = 16'd4915;

    localparam logic [TMAG_W-1:0] FULL_MAG = TMAG_W'(FULL_SCALE);

    // Items that ride beside the divider
    typedef struct packed {
        logic              straight;
        logic              t_neg;
        logic [TMAG_W-1:0] t_mag;
        logic              left_inner;
        logic              neg_inner;
        logic              neg_outer;
    } side_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              neg;
    } wheel_t;

    // Saturate, raise to the minimum, saturate again, then map to a duty
    function automatic wheel_t shape_wheel(
        input logic [QUO_W-1:0]  quo,
        input logic              ovf,
        input logic              neg,
        input side_t             side,
        input logic [CFG_W-1:0]  min_speed
    );
        logic [TMAG_W-1:0] mag;
        logic [CFG_W-1:0]  raised;
        logic [TMAG_W+DUTY_W:0] prod;
        wheel_t res;
        if (side.straight) begin
            mag = side.t_mag;
            res.neg = side.t_neg;
        end else begin
            mag = (ovf || quo > FULL_MAG) ? FULL_MAG : quo;
            res.neg = neg;
        end
        raised = (mag != '0 && mag < min_speed) ? min_speed : mag;
        if (raised > FULL_MAG) begin
            raised = FULL_MAG;
        end
        prod = ({(DUTY_W+1)'(0), raised} << DUTY_W) - {(DUTY_W+1)'(0), raised};
        res.duty = prod[15 +: DUTY_W];
        if (raised == '0) begin
            res.neg = 1'b0;
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/dwd_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwd_front
// Two stages: clamp the throttle and form 2R -/+ W, then the two products.
// ----------------------------------------------------------------------------
module dwd_front import dwd_pkg::*; (
    input  wire logic                    aclk,
    input  wire logic                    en,
    input  wire logic signed [THR_W-1:0] throttle,
    input  wire logic [RAD_W-1:0]        radius_mm,
    input  wire logic [DIR_W-1:0]        turn_dir,
    input  wire logic [CFG_W-1:0]        track_width_mm,
    output      logic [MAG_W-1:0]        mag_inner,
    output      logic [MAG_W-1:0]        mag_outer,
    output      logic [DEN_W-1:0]        den,
    output      side_t                   side
);

    logic [THR_W-1:0]        t_abs;
    logic [DEN_W-1:0]        den_next;
    logic signed [NUM_W:0]   num_in_s;
    side_t                   side_next;

    logic [TMAG_W-1:0]       t_mag_reg;
    logic                    t_neg_reg;
    logic                    straight_reg;
    logic                    left_inner_reg;
    logic [DEN_W-1:0]        den_a_reg;
    logic [NUM_W-1:0]        num_in_reg;
    logic                    num_in_neg_reg;
    logic [NUM_W-1:0]        num_out_reg;

    logic [MAG_W-1:0]        mag_inner_reg;
    logic [MAG_W-1:0]        mag_outer_reg;
    logic [DEN_W-1:0]        den_b_reg;
    side_t                   side_reg;

    always_comb begin
        t_abs    = throttle[THR_W-1] ? (~throttle + 1'b1) : throttle;
        den_next = {radius_mm, 1'b0};
        num_in_s = $signed({2'b00, den_next}) - $signed({3'b000, track_width_mm});
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            t_neg_reg      <= throttle[THR_W-1];
            t_mag_reg      <= (t_abs > THR_W'(FULL_SCALE)) ? FULL_MAG : t_abs[TMAG_W-1:0];
            straight_reg   <= (radius_mm == '0) ||
                              !(turn_dir == DIR_LEFT || turn_dir == DIR_RIGHT);
            left_inner_reg <= (turn_dir == DIR_LEFT);
            den_a_reg      <= den_next;
            num_in_neg_reg <= num_in_s[NUM_W];
            num_in_reg     <= num_in_s[NUM_W] ? NUM_W'(-num_in_s) : num_in_s[NUM_W-1:0];
            num_out_reg    <= {1'b0, den_next} + {2'b00, track_width_mm};
        end
    end

    always_comb begin
        side_next.straight   = straight_reg;
        side_next.t_neg      = t_neg_reg;
        side_next.t_mag      = t_mag_reg;
        side_next.left_inner = left_inner_reg;
        side_next.neg_inner  = t_neg_reg ^ num_in_neg_reg;
        side_next.neg_outer  = t_neg_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_inner_reg <= MAG_W'(t_mag_reg) * MAG_W'(num_in_reg);
            mag_outer_reg <= MAG_W'(t_mag_reg) * MAG_W'(num_out_reg);
            den_b_reg     <= den_a_reg;
            side_reg      <= side_next;
        end
    end

    assign mag_inner = mag_inner_reg;
    assign mag_outer = mag_outer_reg;
    assign den       = den_b_reg;
    assign side      = side_reg;

endmodule
`default_nettype wire

// ----- rtl/dwd_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwd_div
// Pipelined restoring divider: an overflow check, then one quotient bit per
// stage, most significant first.
// ----------------------------------------------------------------------------
module dwd_div import dwd_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             en,
    input  wire logic [MAG_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output      logic [QUO_W-1:0] quo,
    output      logic             ovf
);

    logic [MAG_W-1:0] rem_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];
    logic             ovf_reg [DIV_STAGES];

    logic [MAG_W-1:0] shifted [QUO_W];
    logic             ge      [QUO_W];

    // Stage j tries quotient bit QUO_W-j
    always_comb begin
        for (int j = 1; j < DIV_STAGES; j++) begin
            shifted[j-1] = MAG_W'(den_reg[j-1]) << (QUO_W - j);
            ge[j-1]      = rem_reg[j-1] >= shifted[j-1];
        end
    end

    // Quotient at or above 2^QUO_W counts as saturated
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= dividend;
            den_reg[0] <= divisor;
            quo_reg[0] <= '0;
            ovf_reg[0] <= dividend >= (MAG_W'(divisor) << QUO_W);
            for (int j = 1; j < DIV_STAGES; j++) begin
                rem_reg[j] <= ge[j-1] ? rem_reg[j-1] - shifted[j-1] : rem_reg[j-1];
                den_reg[j] <= den_reg[j-1];
                quo_reg[j] <= quo_reg[j-1] | (QUO_W'(ge[j-1]) << (QUO_W - j));
                ovf_reg[j] <= ovf_reg[j-1];
            end
        end
    end

    assign quo = quo_reg[DIV_STAGES-1];
    assign ovf = ovf_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/dwd_shape.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dwd_shape
// Assign inner and outer to the wheels, shape each value and register the
// four bridge duties.
// ----------------------------------------------------------------------------
module dwd_shape import dwd_pkg::*; (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [QUO_W-1:0]  quo_inner,
    input  wire logic              ovf_inner,
    input  wire logic [QUO_W-1:0]  quo_outer,
    input  wire logic              ovf_outer,
    input  wire side_t             side,
    input  wire logic [CFG_W-1:0]  min_speed,
    output      logic [4*DUTY_W-1:0] duties
);

    wheel_t wl;
    wheel_t wr;
    wheel_t wi;
    wheel_t wo;
    logic [4*DUTY_W-1:0] duties_reg;

    always_comb begin
        wi = shape_wheel(quo_inner, ovf_inner, side.neg_inner, side, min_speed);
        wo = shape_wheel(quo_outer, ovf_outer, side.neg_outer, side, min_speed);
        wl = side.left_inner ? wi : wo;
        wr = side.left_inner ? wo : wi;
    end

    // Left wiring is mirrored: reverse on front, forward on back
    always_ff @(posedge aclk) begin
        if (en) begin
            duties_reg <= {
                wr.neg ? wr.duty : '0,
                wr.neg ? '0 : wr.duty,
                wl.neg ? '0 : wl.duty,
                wl.neg ? wl.duty : '0
            };
        end
    end

    assign duties = duties_reg;

endmodule
`default_nettype wire

// ----- rtl/differential_wheel_drive.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// differential_wheel_drive
// Electronic differential: scales throttle per rear wheel by (2R -/+ W)/2R,
// shapes each wheel value and drives two H-bridge pin pairs.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless stalled; a 17-stage restoring divider
//   per wheel (overflow check, then one quotient bit a stage) sets the depth.
// A stalled output freezes every stage; nothing is dropped or repeated.
// Reset clears all valid bits; registers return to track 200 mm, min 4915.
// ----------------------------------------------------------------------------
module differential_wheel_drive import dwd_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // throttle[16:0], radius_mm[32:17], zero fill[39:33]
    input  wire logic [39:0] s_tdata,
    // turn_dir[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tvalid,
    output      logic        s_tready,
    // left_front_duty[7:0], left_back_duty[15:8],
    // right_front_duty[23:16], right_back_duty[31:24]
    output      logic [31:0] m_tdata,
    output      logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready
);

    logic             en;
    logic [CFG_W-1:0] track_reg;
    logic [CFG_W-1:0] min_reg;
    logic             vld_reg [PIPE_DEPTH];
    logic             m_tvalid_reg;
    side_t            side_reg [DIV_STAGES];

    logic [MAG_W-1:0] mag_inner;
    logic [MAG_W-1:0] mag_outer;
    logic [DEN_W-1:0] den;
    side_t            side_front;
    logic [QUO_W-1:0] quo_inner;
    logic [QUO_W-1:0] quo_outer;
    logic             ovf_inner;
    logic             ovf_outer;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign pready   = 1'b1;

    // Register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            track_reg <= TRACK_RESET;
            min_reg   <= MIN_RESET;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[2])
                REG_TRACK: track_reg <= pwdata[CFG_W-1:0];
                REG_MIN:   min_reg   <= pwdata[CFG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TRACK: prdata = {16'd0, track_reg};
            REG_MIN:   prdata = {16'd0, min_reg};
            default:   prdata = '0;
        endcase
    end

    // Valid bits advance with the data
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_tvalid_reg <= vld_reg[PIPE_DEPTH-1];
        end
    end

    dwd_front u_front (
        .aclk           (aclk),
        .en             (en),
        .throttle       ($signed(s_tdata[THR_W-1:0])),
        .radius_mm      (s_tdata[THR_W +: RAD_W]),
        .turn_dir       (s_tuser[DIR_W-1:0]),
        .track_width_mm (track_reg),
        .mag_inner      (mag_inner),
        .mag_outer      (mag_outer),
        .den            (den),
        .side           (side_front)
    );

    dwd_div u_div_inner (
        .aclk     (aclk),
        .en       (en),
        .dividend (mag_inner),
        .divisor  (den),
        .quo      (quo_inner),
        .ovf      (ovf_inner)
    );

    dwd_div u_div_outer (
        .aclk     (aclk),
        .en       (en),
        .dividend (mag_outer),
        .divisor  (den),
        .quo      (quo_outer),
        .ovf      (ovf_outer)
    );

    // Hold the sideband in step with the dividers
    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_front;
            for (int i = 1; i < DIV_STAGES; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    dwd_shape u_shape (
        .aclk      (aclk),
        .en        (en),
        .quo_inner (quo_inner),
        .ovf_inner (ovf_inner),
        .quo_outer (quo_outer),
        .ovf_outer (ovf_outer),
        .side      (side_reg[DIV_STAGES-1]),
        .min_speed (min_reg),
        .duties    (m_tdata)
    );

    // Each wheel drives at most one pin of its bridge
    a_left_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:0] == '0 || m_tdata[15:8] == '0))
        else $error("left bridge drives both pins");

    a_right_one_pin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[23:16] == '0 || m_tdata[31:24] == '0))
        else $error("right bridge drives both pins");

    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(vld_reg[0]) && $stable(vld_reg[PIPE_DEPTH-1])))
        else $error("pipeline moved during a stall");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule
`default_nettype wire

// ----- tb/differential_wheel_drive_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// differential_wheel_drive_test
// Drives throttle/radius/direction commands into the wheel drive, predicts the
// four H-bridge duties of every command and compares each result transfer
// field by field. Runs several track and minimum-speed settings with random
// back-pressure on both streams.
// ----------------------------------------------------------------------------
module differential_wheel_drive_test;
    import dwd_pkg::*;

    localparam logic [DIR_W-1:0] DIR_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int HOLD_CYCLES     = 80;
    localparam int DRAIN_CYCLES    = 30;
    localparam int STALL_LIMIT     = 1000;

    class wheel_duty_scoreboard;
        logic [31:0]      duty_q[$];
        logic [CFG_W-1:0] track;
        logic [CFG_W-1:0] min_spd;
        int               errors;
        int               commands;
        int               results;

        function new();
            track   = TRACK_RESET;
            min_spd = MIN_RESET;
        endfunction

        function longint saturate(longint v);
            if (v > FULL_SCALE) return FULL_SCALE;
            if (v < -FULL_SCALE) return -FULL_SCALE;
            return v;
        endfunction

        function longint limit_speed(longint v);
            longint m;
            m = min_spd;
            v = saturate(v);
            if (v > 0 && v < m) v = m;
            else if (v < 0 && -v < m) v = -m;
            return saturate(v);
        endfunction

        function logic [DUTY_W-1:0] duty_for(longint v);
            longint mag;
            mag = (v < 0) ? -v : v;
            return DUTY_W'((mag * 255) >>> 15);
        endfunction

        function logic [31:0] predict_duties(logic [THR_W-1:0] thr_bits,
                                             logic [RAD_W-1:0] rad,
                                             logic [DIR_W-1:0] dir);
            longint t, r, den, w, inner, outer, lw, rw;
            t = longint'(signed'(thr_bits));
            t = saturate(t);
            r = rad;
            w = track;
            if (r == 0 || !(dir == DIR_LEFT || dir == DIR_RIGHT)) begin
                lw = t;
                rw = t;
            end else begin
                den   = 2 * r;
                // signed division truncates toward zero
                inner = (t * (den - w)) / den;
                outer = (t * (den + w)) / den;
                lw    = (dir == DIR_LEFT) ? inner : outer;
                rw    = (dir == DIR_LEFT) ? outer : inner;
            end
            lw = limit_speed(lw);
            rw = limit_speed(rw);
            return {(rw < 0) ? duty_for(rw) : 8'd0, (rw > 0) ? duty_for(rw) : 8'd0,
                    (lw > 0) ? duty_for(lw) : 8'd0, (lw < 0) ? duty_for(lw) : 8'd0};
        endfunction

        function void note_command(logic [THR_W-1:0] thr, logic [RAD_W-1:0] rad,
                                   logic [DIR_W-1:0] dir);
            duty_q.push_back(predict_duties(thr, rad, dir));
            commands++;
        endfunction

        function void check_duties(logic [31:0] got);
            logic [31:0] exp_duties;
            string       pin_names[4];
            pin_names = '{"left_front", "left_back", "right_front", "right_back"};
            results++;
            if (duty_q.size() == 0) begin
                $display("%0t: unexpected result transfer, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            exp_duties = duty_q.pop_front();
            for (int i = 0; i < 4; i++) begin
                if (got[8*i +: 8] !== exp_duties[8*i +: 8]) begin
                    $display("%0t: %s_duty mismatch, expected %0d, actual %0d", $time,
                             pin_names[i], exp_duties[8*i +: 8], got[8*i +: 8]);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic [39:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    wheel_duty_scoreboard sb = new();

    int snd_idle_pct  = 0;
    int rcv_idle_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int idle_cycles   = 0;
    int settings_run  = 0;

    differential_wheel_drive uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_duties(m_tdata);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("simulation failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_served != hold_requests) begin
                hold_served++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    task automatic send_command(input logic [THR_W-1:0] thr, input logic [RAD_W-1:0] rad,
                                input logic [DIR_W-1:0] dir);
        if ($urandom_range(99) < snd_idle_pct) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3)) @(negedge aclk);
        end
        @(negedge aclk);
        s_tdata  <= {7'b0, rad, thr};
        s_tuser  <= dir;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_command(thr, rad, dir);
    endtask

    task automatic wait_for_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.duty_q.size() != 0) @(posedge aclk);
    endtask

    task automatic apb_access(input bit is_write, input logic idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rdata = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_register(input logic idx, input logic [CFG_W-1:0] value);
        logic [31:0] rdata;
        apb_access(1'b1, idx, {16'b0, value}, rdata);
        if (idx == REG_TRACK) sb.track = value;
        else sb.min_spd = value;
        apb_access(1'b0, idx, '0, rdata);
        if (rdata[CFG_W-1:0] !== value) begin
            $display("%0t: register %0d readback, expected %0d, actual %0d",
                     $time, idx, value, rdata[CFG_W-1:0]);
            sb.errors++;
        end
    endtask

    initial begin
        logic [CFG_W-1:0] track_set[7];
        logic [CFG_W-1:0] min_set[7];
        logic [THR_W-1:0] thr;
        logic [RAD_W-1:0] rad;
        logic [DIR_W-1:0] dir;
        int               tv;

        track_set = '{16'd200, 16'd0, 16'd65535, 16'd65535, 16'd1, 16'd0, 16'd1000};
        min_set   = '{16'd4915, 16'd0, 16'd32768, 16'd65535, 16'd1, 16'd0, 16'd40000};
        track_set[5] = 16'($urandom());
        min_set[5]   = 16'($urandom_range(32768));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed commands under the reset settings
        send_command(17'd32768, 16'd0, DIR_STRAIGHT);
        send_command(17'h18000, 16'd0, DIR_STRAIGHT);
        send_command(17'd0, 16'd500, DIR_LEFT);
        send_command(17'h1FFFF, 16'd0, DIR_STRAIGHT);
        send_command(17'h10000, 16'd1000, DIR_RIGHT);
        send_command(17'h0FFFF, 16'd1000, DIR_LEFT);
        send_command(17'd10, 16'd300, DIR_UNUSED);
        send_command(17'd20000, 16'd0, DIR_LEFT);
        send_command(17'd20000, 16'd1, DIR_LEFT);
        send_command(-17'sd20000, 16'd1, DIR_RIGHT);
        send_command(17'd1, 16'd100, DIR_LEFT);
        send_command(17'd32768, 16'd100, DIR_RIGHT);
        send_command(17'd32768, 16'd65535, DIR_RIGHT);
        send_command(17'h18000, 16'd65535, DIR_LEFT);
        send_command(17'd16384, 16'd150, DIR_LEFT);
        send_command(-17'sd16384, 16'd150, DIR_RIGHT);
        send_command(17'd100, 16'd2000, DIR_RIGHT);
        send_command(-17'sd100, 16'd2000, DIR_LEFT);
        send_command(17'd30000, 16'd120, DIR_LEFT);
        send_command(17'd12345, 16'd65535, DIR_UNUSED);
        send_command(17'h0AAAA, 16'hAAAA, DIR_RIGHT);
        send_command(17'h15555, 16'h5555, DIR_LEFT);
        wait_for_results();

        for (int ph = 0; ph < 7; ph++) begin
            set_register(REG_TRACK, track_set[ph]);
            set_register(REG_MIN, min_set[ph]);
            settings_run++;
            if (ph < 2) begin
                snd_idle_pct = 7;
                rcv_idle_pct = 53;
            end else if (ph < 4) begin
                snd_idle_pct = 53;
                rcv_idle_pct = 7;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // stall the result stream while commands keep coming
                if (ph == 4 && n == 60) hold_requests++;
                // pause the commands until the pipeline is empty
                if (ph == 5 && n == ITEMS_PER_PHASE / 2) wait_for_results();

                case ($urandom_range(9))
                    0: tv = $urandom();
                    1: tv = $urandom_range(1) ? $urandom_range(6000) : -$urandom_range(6000);
                    2: tv = $urandom_range(1) ? FULL_SCALE - $urandom_range(1)
                                              : -FULL_SCALE + $urandom_range(1);
                    default: tv = $urandom_range(2 * FULL_SCALE) - FULL_SCALE;
                endcase
                thr = THR_W'(tv);
                case ($urandom_range(9)) inside
                    0: rad = '0;
                    [1:3]: rad = RAD_W'($urandom_range(int'(sb.track) / 2 + 50));
                    4: rad = '1;
                    default: rad = RAD_W'($urandom());
                endcase
                case ($urandom_range(9)) inside
                    0: dir = DIR_STRAIGHT;
                    1: dir = DIR_UNUSED;
                    [2:5]: dir = DIR_LEFT;
                    default: dir = DIR_RIGHT;
                endcase
                send_command(thr, rad, dir);
            end
            wait_for_results();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Covered %0d commands and %0d duty results over %0d register settings,",
                 sb.commands, sb.results, settings_run);
        $display("with stalls on both streams and one long output hold-off.");
        if (sb.errors == 0 && sb.duty_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
